[hw/rtl/acdcc_pkg.sv]
package acdcc_pkg;

    localparam int LINE_CAPACITY_DEF = 32;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam logic [7:0] CHAR_DEL = 8'h7f;
    localparam logic [7:0] CHAR_LF  = 8'h0a;
    localparam logic [7:0] CHAR_CR  = 8'h0d;
    localparam logic [7:0] CHAR_R   = 8'h52;
    localparam logic [7:0] CHAR_G   = 8'h47;

    localparam logic [1:0] REPEAT_LAST = 2'd2;

    localparam logic [7:0] PKT_FIRST_BASE  = 8'h80;
    localparam logic [7:0] PKT_SECOND_BASE = 8'hf8;

    // one parsed line, handed from the line editor to the packet emitter
    typedef struct packed {
        logic       ok;
        logic [1:0] pos;
        logic [7:0] addr;
        logic       rg;
    } cmd_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= 8'h61 && c <= 8'h7a)
        begin
            u = c - 8'h20;
        end
        return u;
    endfunction

    // bit 4 set when the character is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] u;
        logic [4:0] v;
        u = upcase(c);
        v = 5'h10;
        if (u >= 8'h30 && u <= 8'h39)
        begin
            v = {1'b0, u[3:0]};
        end
        else if (u >= 8'h41 && u <= 8'h46)
        begin
            v = {1'b0, u[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

[hw/rtl/acdcc_front.sv]
module acdcc_front #(
    parameter int LINE_CAPACITY = acdcc_pkg::LINE_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_in,
    output logic              push,
    output acdcc_pkg::cmd_t   push_cmd,
    input  logic              q_full
);

    localparam int LW = $clog2(LINE_CAPACITY + 1);

    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [7:0]    head_reg [3];
    logic          accept;
    logic          is_eol;
    logic          is_del;
    logic          store;
    logic [4:0]    hi_v;
    logic [4:0]    lo_v;
    logic [7:0]    c2;
    acdcc_pkg::cmd_t cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_del   = (char_in == acdcc_pkg::CHAR_DEL) && (len_reg != '0);
    assign is_eol   = (char_in == acdcc_pkg::CHAR_LF) || (char_in == acdcc_pkg::CHAR_CR);
    assign store    = !is_del && !is_eol && (len_reg < LW'(LINE_CAPACITY));

    assign hi_v = acdcc_pkg::hex_value(head_reg[0]);
    assign lo_v = acdcc_pkg::hex_value(head_reg[1]);
    assign c2   = acdcc_pkg::upcase(head_reg[2]);

    always_comb
    begin
        cmd      = '0;
        cmd.pos  = 2'd0;
        if (hi_v[4])
        begin
            cmd.pos = 2'd0;
        end
        else if (len_reg < LW'(2))
        begin
            cmd.pos = 2'd1;
        end
        else if (lo_v[4])
        begin
            cmd.pos = 2'd1;
        end
        else if (len_reg < LW'(3))
        begin
            cmd.pos = 2'd2;
        end
        else if (c2 != acdcc_pkg::CHAR_R && c2 != acdcc_pkg::CHAR_G)
        begin
            cmd.pos = 2'd2;
        end
        else if (len_reg > LW'(3))
        begin
            cmd.pos = 2'd3;
        end
        else
        begin
            cmd.ok   = 1'b1;
            cmd.addr = {hi_v[3:0], lo_v[3:0]};
            cmd.rg   = (c2 == acdcc_pkg::CHAR_G);
        end
    end

    assign push     = accept && is_eol && (len_reg != '0);
    assign push_cmd = cmd;

    always_comb
    begin
        len_next = len_reg;
        if (accept)
        begin
            if (is_del)
            begin
                len_next = len_reg - LW'(1);
            end
            else if (is_eol)
            begin
                len_next = '0;
            end
            else if (store)
            begin
                len_next = len_reg + LW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // only the first three characters matter to the parser
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (accept && store && (len_reg == LW'(i)))
            begin
                head_reg[i] <= char_in;
            end
        end
    end

endmodule

[hw/rtl/acdcc_queue.sv]
module acdcc_queue #(
    parameter int DEPTH = acdcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  acdcc_pkg::cmd_t push_cmd,
    output logic            full,
    output logic            q_valid,
    output acdcc_pkg::cmd_t q_cmd,
    input  logic            pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    acdcc_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        n = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
        return n;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/acdcc_back.sv]
module acdcc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  acdcc_pkg::cmd_t q_cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            ok,
    output logic [1:0]      error_position,
    output logic [7:0]      accessory_address,
    output logic            red_green,
    output logic [7:0]      packet_first,
    output logic [7:0]      packet_second,
    output logic            last
);

    logic       out_valid_reg;
    logic [1:0] rep_reg;
    logic       load;
    logic       is_last;
    logic       ok_reg;
    logic [1:0] pos_reg;
    logic [7:0] addr_reg;
    logic       rg_reg;
    logic [7:0] first_reg;
    logic [7:0] second_reg;
    logic       last_reg;

    // output stage refills whenever it is empty or its beat is taken
    assign load    = !out_valid_reg || out_ready;
    assign is_last = !q_cmd.ok || (rep_reg == acdcc_pkg::REPEAT_LAST);
    assign pop     = load && q_valid && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rep_reg       <= 2'd0;
        end
        else if (load)
        begin
            out_valid_reg <= q_valid;
            if (q_valid)
            begin
                rep_reg <= is_last ? 2'd0 : rep_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && q_valid)
        begin
            ok_reg   <= q_cmd.ok;
            pos_reg  <= q_cmd.pos;
            addr_reg <= q_cmd.addr;
            rg_reg   <= q_cmd.rg;
            last_reg <= is_last;
            if (q_cmd.ok)
            begin
                first_reg  <= acdcc_pkg::PKT_FIRST_BASE | {2'b00, q_cmd.addr[7:2]};
                second_reg <= acdcc_pkg::PKT_SECOND_BASE
                              | {5'b00000, q_cmd.addr[1:0], q_cmd.rg};
            end
            else
            begin
                first_reg  <= 8'h00;
                second_reg <= 8'h00;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign ok                = ok_reg;
    assign error_position    = pos_reg;
    assign accessory_address = addr_reg;
    assign red_green         = rg_reg;
    assign packet_first      = first_reg;
    assign packet_second     = second_reg;
    assign last              = last_reg;

endmodule

[hw/rtl/accessory_command_line_to_dcc_packet_core.sv]
// a line end is written into the command queue, then its first result beat is loaded into the output stage
// throughput: one character per cycle while the queue is not full; a good command gives three beats, a bad one one beat
// the input stalls only while the command queue between editor and emitter is full
// reset (rst_n, async, active low) empties the line, the command queue and the output stage
module accessory_command_line_to_dcc_packet_core #(
    parameter int LINE_CAPACITY = acdcc_pkg::LINE_CAPACITY_DEF,
    parameter int QUEUE_DEPTH   = acdcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       ok,
    output logic [1:0] error_position,
    output logic [7:0] accessory_address,
    output logic       red_green,
    output logic [7:0] packet_first,
    output logic [7:0] packet_second,
    output logic       last
);

    logic            push;
    acdcc_pkg::cmd_t push_cmd;
    logic            q_full;
    logic            q_valid;
    acdcc_pkg::cmd_t q_cmd;
    logic            pop;

    acdcc_front #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .char_in  (char_in),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    acdcc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    acdcc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_cmd             (q_cmd),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .ok                (ok),
        .error_position    (error_position),
        .accessory_address (accessory_address),
        .red_green         (red_green),
        .packet_first      (packet_first),
        .packet_second     (packet_second),
        .last              (last)
    );

endmodule

[test/tb_accessory_command_line_to_dcc_packet_core.sv]
`timescale 1ns / 1ps

module tb_accessory_command_line_to_dcc_packet_core;

    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 250;
    localparam int CHAR_TARGET = 225;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef struct {
        logic [7:0] code;
        bit         wait_idle;
    } typed_char_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] error_position;
        logic [7:0] accessory_address;
        logic       red_green;
        logic [7:0] packet_first;
        logic [7:0] packet_second;
        logic       last;
    } line_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_in = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       ok;
    logic [1:0] error_position;
    logic [7:0] accessory_address;
    logic       red_green;
    logic [7:0] packet_first;
    logic [7:0] packet_second;
    logic       last;

    typed_char_t typed_chars[$];
    line_beat_t  awaited_beats[$];

    // line editor copy
    logic [7:0] line_len = 8'd0;
    logic [7:0] head_chars[3];

    int  queued_total   = 0;
    int  chars_accepted = 0;
    int  beats_checked  = 0;
    int  good_lines     = 0;
    int  bad_lines      = 0;
    int  full_drops     = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;
    int  gap_left       = 0;
    int  burst_left     = 1;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    int  rx_mode        = 0;
    int  rx_mode_left   = 0;
    bit  next_wait_idle = 1'b0;
    bit  [3:0] pos_seen = '0;

    accessory_command_line_to_dcc_packet_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .char_in           (char_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .ok                (ok),
        .error_position    (error_position),
        .accessory_address (accessory_address),
        .red_green         (red_green),
        .packet_first      (packet_first),
        .packet_second     (packet_second),
        .last              (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_LO_A && c <= CH_LO_Z)
        begin
            return c - CASE_GAP;
        end
        return c;
    endfunction

    // -1 when not a hex digit
    function automatic int nibble_of(input logic [7:0] c);
        logic [7:0] u;
        u = fold_case(c);
        if (u >= CH_0 && u <= CH_9)
        begin
            return int'(u - CH_0);
        end
        if (u >= CH_A && u <= CH_F)
        begin
            return int'(u - CH_A) + 10;
        end
        return -1;
    endfunction

    task automatic close_line();
        int         hi;
        int         lo;
        int         pos;
        logic [7:0] third;
        logic [7:0] addr;
        line_beat_t b;
        b = '0;
        b.last = 1'b1;
        pos = -1;
        lo = 0;
        hi = nibble_of(head_chars[0]);
        if (hi < 0)
        begin
            pos = 0;
        end
        else if (line_len < 2)
        begin
            pos = 1;
        end
        else
        begin
            lo = nibble_of(head_chars[1]);
            third = fold_case(head_chars[2]);
            if (lo < 0)
            begin
                pos = 1;
            end
            else if (line_len < 3)
            begin
                pos = 2;
            end
            else if (third != acdcc_pkg::CHAR_R && third != acdcc_pkg::CHAR_G)
            begin
                pos = 2;
            end
            else if (line_len > 3)
            begin
                pos = 3;
            end
        end
        if (pos >= 0)
        begin
            b.error_position = pos[1:0];
            pos_seen[pos] = 1'b1;
            bad_lines++;
            awaited_beats.push_back(b);
        end
        else
        begin
            addr = {hi[3:0], lo[3:0]};
            b.ok = 1'b1;
            b.accessory_address = addr;
            b.red_green = (third == acdcc_pkg::CHAR_G);
            b.packet_first = {2'b10, addr[7:2]};
            b.packet_second = {5'b11111, addr[1:0], b.red_green};
            good_lines++;
            // same packet three times, last flag on the third
            b.last = 1'b0;
            awaited_beats.push_back(b);
            awaited_beats.push_back(b);
            b.last = 1'b1;
            awaited_beats.push_back(b);
        end
    endtask

    task automatic edit_line(input logic [7:0] c);
        chars_accepted++;
        if (c == acdcc_pkg::CHAR_DEL && line_len != 0)
        begin
            line_len--;
        end
        else if (c == acdcc_pkg::CHAR_CR || c == acdcc_pkg::CHAR_LF)
        begin
            if (line_len != 0)
            begin
                close_line();
                line_len = 0;
            end
        end
        else if (line_len >= acdcc_pkg::LINE_CAPACITY_DEF)
        begin
            full_drops++;
        end
        else
        begin
            if (line_len < 3)
            begin
                head_chars[line_len] = c;
            end
            line_len++;
        end
    endtask

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        mismatches++;
        if (mismatches <= 20)
        begin
            $display("mismatch after %0d beats: %s got %0h expected %0h",
                     beats_checked, what, got, want);
        end
    endtask

    task automatic push_char(input logic [7:0] c);
        typed_char_t t;
        t.code = c;
        t.wait_idle = next_wait_idle;
        next_wait_idle = 1'b0;
        typed_chars.push_back(t);
        queued_total++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i]);
        end
    endtask

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return CH_0 + 8'(v);
        end
        return (($urandom_range(0, 1) != 0) ? CH_A : CH_LO_A) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] rg_char();
        logic [7:0] c;
        c = ($urandom_range(0, 1) != 0) ? acdcc_pkg::CHAR_G : acdcc_pkg::CHAR_R;
        if ($urandom_range(0, 1) != 0)
        begin
            c = c + CASE_GAP;
        end
        return c;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == acdcc_pkg::CHAR_CR || c == acdcc_pkg::CHAR_LF
               || c == acdcc_pkg::CHAR_DEL);
        return c;
    endfunction

    function automatic logic [7:0] line_end();
        return ($urandom_range(0, 1) != 0) ? acdcc_pkg::CHAR_CR : acdcc_pkg::CHAR_LF;
    endfunction

    task automatic push_command();
        push_char(hex_char());
        if ($urandom_range(0, 3) == 0)
        begin
            push_char(junk_char());
            push_char(acdcc_pkg::CHAR_DEL);
        end
        push_char(hex_char());
        push_char(rg_char());
        push_char(line_end());
    endtask

    task automatic push_broken();
        case ($urandom_range(0, 5))
            0:
            begin
                push_char(junk_char());
                push_char(hex_char());
                push_char(rg_char());
            end
            1:
            begin
                push_char(hex_char());
            end
            2:
            begin
                push_char(hex_char());
                push_char(junk_char());
                push_char(rg_char());
            end
            3:
            begin
                push_char(hex_char());
                push_char(hex_char());
            end
            4:
            begin
                push_char(hex_char());
                push_char(hex_char());
                push_char(junk_char());
            end
            default:
            begin
                push_char(hex_char());
                push_char(hex_char());
                push_char(rg_char());
                push_char(junk_char());
            end
        endcase
        push_char(line_end());
    endtask

    task automatic push_long(input int n);
        for (int i = 0; i < n; i++)
        begin
            push_char(junk_char());
        end
        push_char(line_end());
    endtask

    // sender: bursts of characters with random gaps
    always @(posedge clk)
    begin
        typed_char_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                edit_line(char_in);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (typed_chars.size() > 0 &&
                     !(typed_chars[0].wait_idle && awaited_beats.size() > 0))
            begin
                nxt = typed_chars.pop_front();
                char_in <= nxt.code;
                in_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern in random modes plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && chars_accepted >= 50)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(8, 60);
            end
            else
            begin
                rx_mode_left--;
            end
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) != 0);
                2:       out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        line_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_beats.size() == 0)
            begin
                report("beat with nothing expected", 8'd0, 8'd0);
            end
            else
            begin
                want = awaited_beats.pop_front();
                beats_checked++;
                if (ok !== want.ok)
                    report("ok", ok, want.ok);
                if (error_position !== want.error_position)
                    report("error_position", error_position, want.error_position);
                if (accessory_address !== want.accessory_address)
                    report("accessory_address", accessory_address, want.accessory_address);
                if (red_green !== want.red_green)
                    report("red_green", red_green, want.red_green);
                if (packet_first !== want.packet_first)
                    report("packet_first", packet_first, want.packet_first);
                if (packet_second !== want.packet_second)
                    report("packet_second", packet_second, want.packet_second);
                if (last !== want.last)
                    report("last", last, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("timeout with %0d beats still expected", awaited_beats.size());
            $display("** accessory_command_line_to_dcc_packet_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        bit mid_done;
        int kind;
        mid_done = 1'b0;

        // directed lines
        push_char(acdcc_pkg::CHAR_CR);
        push_char(acdcc_pkg::CHAR_DEL);
        push_char(acdcc_pkg::CHAR_CR);
        push_text("a");
        push_char(acdcc_pkg::CHAR_LF);
        push_text("Fz");
        push_char(acdcc_pkg::CHAR_CR);
        push_text("7e");
        push_char(acdcc_pkg::CHAR_LF);
        push_text("12x");
        push_char(acdcc_pkg::CHAR_CR);
        push_text("ffgX");
        push_char(acdcc_pkg::CHAR_DEL);
        push_char(acdcc_pkg::CHAR_CR);
        push_text("00R");
        push_char(acdcc_pkg::CHAR_LF);
        push_text("3cr");
        push_char('0);
        push_char('1);
        push_char(acdcc_pkg::CHAR_CR);

        // random lines, mostly well formed
        next_wait_idle = 1'b1;
        while (queued_total < CHAR_TARGET)
        begin
            if (!mid_done && queued_total >= 150)
            begin
                // pause until drained, then overflow the line buffer
                mid_done = 1'b1;
                next_wait_idle = 1'b1;
                push_long(acdcc_pkg::LINE_CAPACITY_DEF + 3);
            end
            kind = $urandom_range(0, 10);
            if (kind <= 5)
            begin
                push_command();
            end
            else if (kind <= 7)
            begin
                push_broken();
            end
            else if (kind == 8)
            begin
                push_long(($urandom_range(0, 3) == 0) ? $urandom_range(33, 40)
                                                      : $urandom_range(4, 10));
            end
            else if (kind == 9)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    push_char(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    push_char(($urandom_range(0, 1) != 0) ? acdcc_pkg::CHAR_DEL
                                                          : line_end());
                end
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(posedge clk);
        end
        while (chars_accepted < queued_total || awaited_beats.size() > 0);
        repeat (16) @(posedge clk);
        if (awaited_beats.size() != 0)
        begin
            report("beats never delivered", 8'(awaited_beats.size()), 8'd0);
        end

        $display("%0d characters edited, %0d good commands, %0d bad lines, %0d beats checked",
                 chars_accepted, good_lines, bad_lines, beats_checked);
        $display("error positions seen %b, %0d chars dropped on a full line, %0d cycle hold",
                 pos_seen, full_drops, HOLD_CYCLES);
        if (mismatches == 0)
        begin
            $display("** accessory_command_line_to_dcc_packet_core: PASSED **");
        end
        else
        begin
            $display("** accessory_command_line_to_dcc_packet_core: FAILED **");
        end
        $finish;
    end

endmodule
